FILE: sv/cas_pkg.sv
// ----------------------------------------------------------------------------
// cas_pkg: shared types, constants and helpers for the attack set generator
// Piece codes, offset tables, the per-stage ray record and square helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cas_pkg;

  localparam int NUM_CELLS = 7;   // longest ray on an 8x8 board
  localparam int NUM_RAYS  = 4;

  localparam logic [2:0] CMD_WHITE_PAWN = 3'd0;
  localparam logic [2:0] CMD_BLACK_PAWN = 3'd1;
  localparam logic [2:0] CMD_KNIGHT     = 3'd2;
  localparam logic [2:0] CMD_KING       = 3'd3;
  localparam logic [2:0] CMD_ROOK       = 3'd4;
  localparam logic [2:0] CMD_BISHOP     = 3'd5;

  localparam logic signed [3:0] LEAP_DF [8] = '{-4'sd2, -4'sd2, -4'sd1, -4'sd1,
                                                 4'sd1,  4'sd1,  4'sd2,  4'sd2};
  localparam logic signed [3:0] LEAP_DR [8] = '{-4'sd1,  4'sd1, -4'sd2,  4'sd2,
                                                -4'sd2,  4'sd2, -4'sd1,  4'sd1};
  localparam logic signed [3:0] STEP_DF [8] = '{-4'sd1, -4'sd1, -4'sd1,  4'sd0,
                                                 4'sd0,  4'sd1,  4'sd1,  4'sd1};
  localparam logic signed [3:0] STEP_DR [8] = '{-4'sd1,  4'sd0,  4'sd1, -4'sd1,
                                                 4'sd1, -4'sd1,  4'sd0,  4'sd1};

  localparam logic signed [3:0] ORTH_DF [NUM_RAYS] = '{4'sd0, 4'sd0, 4'sd1, -4'sd1};
  localparam logic signed [3:0] ORTH_DR [NUM_RAYS] = '{4'sd1, -4'sd1, 4'sd0, 4'sd0};
  localparam logic signed [3:0] DIAG_DF [NUM_RAYS] = '{4'sd1, 4'sd1, -4'sd1, -4'sd1};
  localparam logic signed [3:0] DIAG_DR [NUM_RAYS] = '{4'sd1, -4'sd1, 4'sd1, -4'sd1};

  typedef struct packed {
    logic [2:0] file;
    logic [2:0] rank;
    logic       alive;
  } ray_t;

  typedef struct packed {
    logic                 diag;
    logic [63:0]          occ;
    logic [63:0]          acc;
    ray_t [NUM_RAYS-1:0]  ray;
  } stage_t;

  // Single-bit board for (file+df, rank+dr), empty when off the board.
  function automatic logic [63:0] spot(input logic [2:0] file, input logic [2:0] rank,
                                       input logic signed [3:0] df,
                                       input logic signed [3:0] dr);
    logic signed [3:0] nf;
    logic signed [3:0] nr;
    nf = $signed({1'b0, file}) + df;
    nr = $signed({1'b0, rank}) + dr;
    if (nf[3] || nr[3]) begin
      spot = 64'd0;
    end else begin
      spot = 64'd1 << {nr[2:0], nf[2:0]};
    end
  endfunction

  // Knight (king = 0) or king (king = 1) offset set.
  function automatic logic [63:0] offset_set(input logic [2:0] file, input logic [2:0] rank,
                                             input logic king);
    logic [63:0] acc;
    acc = 64'd0;
    for (int i = 0; i < 8; i++) begin
      if (king) begin
        acc = acc | spot(file, rank, STEP_DF[i], STEP_DR[i]);
      end else begin
        acc = acc | spot(file, rank, LEAP_DF[i], LEAP_DR[i]);
      end
    end
    return acc;
  endfunction

endpackage

FILE: sv/cas_req_if.sv
// ----------------------------------------------------------------------------
// cas_req_if: request channel
// Valid/ready channel carrying piece kind, origin square and occupancy.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cas_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [5:0]  square;
  logic [63:0] occupancy;

  modport source (output valid, output command, output square, output occupancy,
                  input ready);
  modport sink   (input valid, input command, input square, input occupancy,
                  output ready);
endinterface

FILE: sv/cas_rsp_if.sv
// ----------------------------------------------------------------------------
// cas_rsp_if: result channel
// Valid/ready channel carrying the 64-bit attack set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cas_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] attacks;

  modport source (output valid, output attacks, input ready);
  modport sink   (input valid, input attacks, output ready);
endinterface

FILE: sv/cas_seed.sv
// ----------------------------------------------------------------------------
// cas_seed: request decode
// Build the fixed-offset set for pawns, knight and king, and launch the four
// rays at the origin for rook and bishop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cas_seed (
  input  logic [2:0]      command,
  input  logic [5:0]      square,
  input  logic [63:0]     occupancy,
  output cas_pkg::stage_t seed
);

  logic [2:0] file;
  logic [2:0] rank;
  logic       slider;

  assign file   = square[2:0];
  assign rank   = square[5:3];
  assign slider = (command == cas_pkg::CMD_ROOK) || (command == cas_pkg::CMD_BISHOP);

  always_comb begin
    seed.diag = (command == cas_pkg::CMD_BISHOP);
    seed.occ  = occupancy;
    for (int d = 0; d < cas_pkg::NUM_RAYS; d++) begin
      seed.ray[d].file  = file;
      seed.ray[d].rank  = rank;
      seed.ray[d].alive = slider;
    end
    case (command)
      cas_pkg::CMD_WHITE_PAWN: begin
        seed.acc = cas_pkg::spot(file, rank, -4'sd1, 4'sd1)
                 | cas_pkg::spot(file, rank,  4'sd1, 4'sd1);
      end
      cas_pkg::CMD_BLACK_PAWN: begin
        seed.acc = cas_pkg::spot(file, rank, -4'sd1, -4'sd1)
                 | cas_pkg::spot(file, rank,  4'sd1, -4'sd1);
      end
      cas_pkg::CMD_KNIGHT: begin
        seed.acc = cas_pkg::offset_set(file, rank, 1'b0);
      end
      cas_pkg::CMD_KING: begin
        seed.acc = cas_pkg::offset_set(file, rank, 1'b1);
      end
      default: begin
        seed.acc = 64'd0;
      end
    endcase
  end

endmodule

FILE: sv/cas_cell.sv
// ----------------------------------------------------------------------------
// cas_cell: one ray step
// Advance every live ray by one square, mark it, and stop the ray on the
// board edge or on the first occupied square. Register the beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cas_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  cas_pkg::stage_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output cas_pkg::stage_t out_data
);

  logic            valid;
  cas_pkg::stage_t data;
  cas_pkg::stage_t data_next;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_comb begin
    logic signed [3:0] df;
    logic signed [3:0] dr;
    logic signed [3:0] nf;
    logic signed [3:0] nr;
    logic [5:0]        idx;
    data_next = in_data;
    for (int d = 0; d < cas_pkg::NUM_RAYS; d++) begin
      df  = in_data.diag ? cas_pkg::DIAG_DF[d] : cas_pkg::ORTH_DF[d];
      dr  = in_data.diag ? cas_pkg::DIAG_DR[d] : cas_pkg::ORTH_DR[d];
      nf  = $signed({1'b0, in_data.ray[d].file}) + df;
      nr  = $signed({1'b0, in_data.ray[d].rank}) + dr;
      idx = {nr[2:0], nf[2:0]};
      if (in_data.ray[d].alive) begin
        if (nf[3] || nr[3]) begin
          data_next.ray[d].alive = 1'b0;
        end else begin
          data_next.acc           = data_next.acc | (64'd1 << idx);
          data_next.ray[d].file   = nf[2:0];
          data_next.ray[d].rank   = nr[2:0];
          data_next.ray[d].alive  = !in_data.occ[idx];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

endmodule

FILE: sv/chess_attack_set_generator.sv
// ----------------------------------------------------------------------------
// chess_attack_set_generator: bitboard attack set for one piece per beat
// Path: a request beat is registered in each of the seven ray cells in turn.
// Throughput: one beat per cycle; each cell stalls only when it and all cells
// downstream are full, so the chain keeps filling while a result waits.
// Reset: synchronous, active high; empties every cell, payload is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chess_attack_set_generator (
  input  logic         clk,
  input  logic         rst,
  cas_req_if.sink      req,
  cas_rsp_if.source    rsp
);

  // Chain of ray cells. Index 0 is the decoded request, index NUM_CELLS is
  // the last cell's register, which doubles as the result register.
  cas_pkg::stage_t                stage [cas_pkg::NUM_CELLS+1];
  logic [cas_pkg::NUM_CELLS:0]    vld;
  logic [cas_pkg::NUM_CELLS:0]    rdy;

  // Decode: pawns, knight and king finish here; sliders launch four rays
  // from the origin. The origin's own occupancy bit is never probed.
  cas_seed u_seed (
    .command   (req.command),
    .square    (req.square),
    .occupancy (req.occupancy),
    .seed      (stage[0])
  );

  assign vld[0]    = req.valid;
  assign req.ready = rdy[0];

  // Seven identical cells, each walking every ray one square further.
  // A rook or bishop ray never needs more than seven steps.
  for (genvar k = 0; k < cas_pkg::NUM_CELLS; k++) begin : g_cell
    cas_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vld[k]),
      .in_ready  (rdy[k]),
      .in_data   (stage[k]),
      .out_valid (vld[k+1]),
      .out_ready (rdy[k+1]),
      .out_data  (stage[k+1])
    );
  end

  // Last cell holds the result beat until the sink takes it.
  assign rsp.valid                  = vld[cas_pkg::NUM_CELLS];
  assign rdy[cas_pkg::NUM_CELLS]    = rsp.ready;
  assign rsp.attacks                = stage[cas_pkg::NUM_CELLS].acc;

  // A request beat always lands in the first cell.
  a_first_cell_loads: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> vld[1])
    else $error("request beat did not enter the first cell");

  // A waiting result beat holds steady until the sink takes it.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.attacks))
    else $error("result beat changed while waiting");

  // Reset empties the chain.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (vld[cas_pkg::NUM_CELLS:1] == '0))
    else $error("cell valid after reset");

  // A cell that is full and blocked downstream refuses new beats.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    vld[1] && !rdy[1] |-> !rdy[0])
    else $error("first cell accepted while blocked");

endmodule
